### hdl/cp1251_pkg.sv
// Shared types, constants and the upper-half code point table for the CP1251 to UTF-8 unit.
package cp1251_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [15:0] CYR_BASE_CP   = 16'h0410;
	localparam logic [7:0]  CYR_BASE_BYTE = 8'hC0;
	localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
	localparam logic [15:0] ONE_BYTE_MAX  = 16'h007F;
	localparam logic [15:0] TWO_BYTE_MAX  = 16'h07FF;
	localparam logic [7:0]  LEAD2_MARK    = 8'hC0;
	localparam logic [7:0]  LEAD3_MARK    = 8'hE0;
	localparam logic [7:0]  CONT_MARK     = 8'h80;

	// Code points for bytes 0x80..0xBF; the unassigned 0x98 becomes '?'.
	localparam logic [15:0] UPPER_HALF [64] = '{
		16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
		16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h003F, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
		16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
		16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
		16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
		16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
	};

	typedef enum logic [1:0] {
		LEN_ONE   = 2'd1,
		LEN_TWO   = 2'd2,
		LEN_THREE = 2'd3
	} len_t;

	typedef struct packed {
		logic [15:0] cp;
		len_t        len;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} qport_t;

endpackage

### hdl/cp1251_to_utf8_transcoder_unit.sv
// Top level of the CP1251 to UTF-8 transcoder unit.
//
// Input channel: drive source_byte and raise start; the byte is taken at a
// rising clock edge where start is high and busy is low. busy rises only
// when the internal queue is full.
// Output channel: each UTF-8 byte appears on utf8_byte for one cycle with
// strobe high; last_of_run marks the final byte of the run for one input.
// The receiver cannot stall, so every strobe is a completed transaction.
// A run is one byte for ASCII, two for code points up to U+07FF and three
// above; the bytes of a run come on consecutive cycles.
// When the serializer is free, an accepted byte passes through the queue,
// the serializer's current-entry register and the output register before its
// first byte strobes. Throughput is one output byte per cycle; an item holds
// the serializer until its run drains; the queue lets the front keep accepting.
// Reset (arst_n low) empties the queue and drops any run in progress;
// strobe is low out of reset.
module cp1251_to_utf8_transcoder_unit #(
	parameter int unsigned QueueDepth = cp1251_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] source_byte,
	output logic       strobe,
	output logic [7:0] utf8_byte,
	output logic       last_of_run
);

	cp1251_pkg::qport_t push;
	cp1251_pkg::qport_t head;
	logic               pop;

	cp1251_front u_front (
		.start       (start),
		.busy        (busy),
		.source_byte (source_byte),
		.push        (push)
	);

	cp1251_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (busy)
	);

	cp1251_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.strobe      (strobe),
		.utf8_byte   (utf8_byte),
		.last_of_run (last_of_run)
	);

	// A run continues on the very next cycle until its last byte.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_run |=> strobe)
		else $error("UTF-8 run broken before its last byte");

	// No run is longer than three bytes.
	a_run_max3: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_run && $past(strobe && !last_of_run) |=> last_of_run)
		else $error("UTF-8 run longer than three bytes");

	// Lead byte of a multi-byte run carries the 11 prefix.
	a_lead_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_run && !$past(strobe && !last_of_run)
		|-> utf8_byte[7:6] == 2'b11)
		else $error("multi-byte run without a lead byte");

	// Bytes after the lead are continuation bytes.
	a_cont_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe && !last_of_run) |-> utf8_byte[7:6] == 2'b10)
		else $error("continuation byte without 10 prefix");

endmodule

### hdl/cp1251_front.sv
// Front end: maps a CP1251 byte to its code point and UTF-8 run length.
module cp1251_front (
	input  logic                 start,
	input  logic                 busy,
	input  logic [7:0]           source_byte,
	output cp1251_pkg::qport_t   push
);

	logic [15:0] cp;

	always_comb begin
		if (source_byte < cp1251_pkg::ASCII_LIMIT) begin
			cp = {8'h00, source_byte};
		end else if (source_byte >= cp1251_pkg::CYR_BASE_BYTE) begin
			cp = cp1251_pkg::CYR_BASE_CP + {10'd0, source_byte[5:0]};
		end else begin
			cp = cp1251_pkg::UPPER_HALF[source_byte[5:0]];
		end
	end

	always_comb begin
		push.valid    = start && !busy;
		push.entry.cp = cp;
		if (cp <= cp1251_pkg::ONE_BYTE_MAX) begin
			push.entry.len = cp1251_pkg::LEN_ONE;
		end else if (cp <= cp1251_pkg::TWO_BYTE_MAX) begin
			push.entry.len = cp1251_pkg::LEN_TWO;
		end else begin
			push.entry.len = cp1251_pkg::LEN_THREE;
		end
	end

endmodule

### hdl/cp1251_queue.sv
// Small register queue between the classifying front end and the byte serializer.
module cp1251_queue #(
	parameter int unsigned Depth = cp1251_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cp1251_pkg::qport_t   push,
	input  logic                 pop,
	output cp1251_pkg::qport_t   head,
	output logic                 full
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	cp1251_pkg::qentry_t mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_pop;

	assign full       = (count_q == FullCnt);
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/cp1251_back.sv
// Back end: serializes one queued code point into its UTF-8 bytes, one per cycle.
module cp1251_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cp1251_pkg::qport_t   head,
	output logic                 pop,
	output logic                 strobe,
	output logic [7:0]           utf8_byte,
	output logic                 last_of_run
);

	logic                active_q;
	cp1251_pkg::qentry_t cur_q;
	logic [1:0]          pos_q;
	logic [7:0]          byte_d;
	logic                last_d;
	logic                strobe_q;
	logic [7:0]          byte_q;
	logic                last_q;

	assign last_d = (pos_q == (cur_q.len - 2'd1));
	assign pop    = !active_q || last_d;

	always_comb begin
		case (cur_q.len)
			cp1251_pkg::LEN_ONE: begin
				byte_d = cur_q.cp[7:0];
			end
			cp1251_pkg::LEN_TWO: begin
				if (pos_q == 2'd0) begin
					byte_d = cp1251_pkg::LEAD2_MARK | {3'd0, cur_q.cp[10:6]};
				end else begin
					byte_d = cp1251_pkg::CONT_MARK | {2'd0, cur_q.cp[5:0]};
				end
			end
			cp1251_pkg::LEN_THREE: begin
				case (pos_q)
					2'd0:    byte_d = cp1251_pkg::LEAD3_MARK | {4'd0, cur_q.cp[15:12]};
					2'd1:    byte_d = cp1251_pkg::CONT_MARK | {2'd0, cur_q.cp[11:6]};
					default: byte_d = cp1251_pkg::CONT_MARK | {2'd0, cur_q.cp[5:0]};
				endcase
			end
			default: begin
				byte_d = cur_q.cp[7:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (active_q && !last_d) begin
				pos_q <= pos_q + 2'd1;
			end else begin
				// load the next code point, or go idle
				active_q <= head.valid;
				pos_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.valid) begin
			cur_q <= head.entry;
		end
		byte_q <= byte_d;
		last_q <= last_d;
	end

	assign strobe      = strobe_q;
	assign utf8_byte   = byte_q;
	assign last_of_run = last_q;

endmodule

### dv/cp1251_to_utf8_transcoder_unit_tb.sv
// Self-checking testbench for the CP1251 to UTF-8 transcoder unit.
module cp1251_to_utf8_transcoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 270;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;

	localparam logic [7:0]  UNDEF_BYTE    = 8'h98;
	localparam logic [15:0] QUESTION_CP   = 16'h003F;
	localparam logic [7:0]  HIGH_FIRST    = 8'h80;
	localparam logic [7:0]  CYR_FIRST     = 8'hC0;
	localparam logic [15:0] CYR_CP_BASE   = 16'h0410;
	localparam logic [15:0] ONE_BYTE_LAST = 16'h007F;
	localparam logic [15:0] TWO_BYTE_LAST = 16'h07FF;

	// Windows-1251 assignments for 0x80..0xBF; the unassigned 0x98 holds '?'
	localparam logic [15:0] HIGH_ROW_CP [64] = '{
		16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
		16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h003F, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
		16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
		16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
		16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
		16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
	};

	typedef struct {
		logic [7:0]  src;
		int unsigned gap;
		bit          drain;
	} src_item_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} utf8_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [7:0] source_byte = 8'h00;
	logic       busy;
	logic       strobe;
	logic [7:0] utf8_byte;
	logic       last_of_run;

	src_item_t   src_q[$];
	utf8_out_t   utf8_expect_q[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	cp1251_to_utf8_transcoder_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.source_byte (source_byte),
		.strobe      (strobe),
		.utf8_byte   (utf8_byte),
		.last_of_run (last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] cp1251_code_point(input logic [7:0] b);
		if (b == UNDEF_BYTE)
			return QUESTION_CP;
		if (b < HIGH_FIRST)
			return {8'h00, b};
		if (b >= CYR_FIRST)
			return CYR_CP_BASE + 16'(b - CYR_FIRST);
		return HIGH_ROW_CP[b[5:0]];
	endfunction

	task automatic push_utf8_run(input logic [7:0] b);
		logic [15:0] cp;
		cp = cp1251_code_point(b);
		if (cp <= ONE_BYTE_LAST) begin
			utf8_expect_q.insert(utf8_expect_q.size(), '{value: cp[7:0], last: 1'b1});
		end else if (cp <= TWO_BYTE_LAST) begin
			utf8_expect_q.insert(utf8_expect_q.size(),
				'{value: {3'b110, cp[10:6]}, last: 1'b0});
			utf8_expect_q.insert(utf8_expect_q.size(),
				'{value: {2'b10, cp[5:0]}, last: 1'b1});
		end else begin
			utf8_expect_q.insert(utf8_expect_q.size(),
				'{value: {4'b1110, cp[15:12]}, last: 1'b0});
			utf8_expect_q.insert(utf8_expect_q.size(),
				'{value: {2'b10, cp[11:6]}, last: 1'b0});
			utf8_expect_q.insert(utf8_expect_q.size(),
				'{value: {2'b10, cp[5:0]}, last: 1'b1});
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned random_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] random_source();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 8'($urandom_range(0, 8'h7F));
		if (r < 60)
			return 8'($urandom_range(8'h80, 8'hBF));
		return 8'($urandom_range(8'hC0, 8'hFF));
	endfunction

	always @(posedge clk) begin : drive_proc
		logic       next_start;
		logic [7:0] next_byte;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				push_utf8_run(source_byte);
			if (start && busy) begin
				// hold the transaction until it is taken
				next_start = 1'b1;
				next_byte  = source_byte;
			end else begin
				next_start = 1'b0;
				next_byte  = 8'($urandom_range(0, 255));
				if (src_q.size() != 0) begin
					if (src_q[0].gap != 0) begin
						src_q[0].gap--;
					end else if (!(src_q[0].drain && utf8_expect_q.size() != 0)) begin
						next_start = 1'b1;
						next_byte  = src_q[0].src;
						void'(src_q.pop_front());
					end
				end
			end
			start       <= next_start;
			source_byte <= next_byte;
		end
	end

	always @(posedge clk) begin : check_proc
		utf8_out_t exp_out;
		if (arst_n && strobe) begin
			if (utf8_expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected byte: expected none, actual %02h last %0b",
					$time, utf8_byte, last_of_run);
			end else begin
				exp_out = utf8_expect_q.pop_front();
				if (utf8_byte !== exp_out.value) begin
					mismatches++;
					$display("%0t: utf8_byte mismatch: expected %02h, actual %02h",
						$time, exp_out.value, utf8_byte);
				end
				if (last_of_run !== exp_out.last) begin
					mismatches++;
					$display("%0t: last_of_run mismatch: expected %0b, actual %0b",
						$time, exp_out.last, last_of_run);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("cp1251_to_utf8_transcoder_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin : stim_proc
		logic [7:0] directed [$];
		directed = '{8'h00, 8'h7F, 8'h01, 8'h40, 8'h80, 8'h81, 8'h88, 8'h97, 8'h98, 8'h99,
			8'h9F, 8'hA0, 8'hA5, 8'hAA, 8'hB9, 8'hBF, 8'hC0, 8'hC1, 8'hDF, 8'hE0,
			8'hFE, 8'hFF, 8'h55};
		// first few directed items go back to back
		foreach (directed[i])
			src_q.insert(src_q.size(),
				'{src: directed[i], gap: (i < 6) ? 0 : random_gap(), drain: 1'b0});
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			src_q.insert(src_q.size(), '{src: random_source(),
				gap: (i >= 100 && i < 160) ? 0 : random_gap(),
				drain: (i == 0 || i == 160 || i == 230)});
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// sample between edges so the driver's updates have settled
		while (src_q.size() != 0 || start)
			@(negedge clk);
		while (utf8_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && utf8_expect_q.size() == 0)
			$display("cp1251_to_utf8_transcoder_unit_tb: done, clean");
		else
			$display("cp1251_to_utf8_transcoder_unit_tb: done, errors");
		$finish;
	end

endmodule

### cp1251_to_utf8_transcoder_unit.f
hdl/cp1251_pkg.sv
hdl/cp1251_front.sv
hdl/cp1251_queue.sv
hdl/cp1251_back.sv
hdl/cp1251_to_utf8_transcoder_unit.sv
dv/cp1251_to_utf8_transcoder_unit_tb.sv
